@@ hdl/mqcf_pkg.sv @@
// Shared types and constants for the mask quad corner finder.
package mqcf_pkg;

  // Fixed field widths of the channels.
  localparam int ALPHA_W   = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 4;
  localparam int OUT_W     = 12;

  // Register reset values.
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Corner slots of the candidate store.
  localparam int NUM_CORNERS = 4;
  localparam int CORNER_TL   = 0;
  localparam int CORNER_TR   = 1;
  localparam int CORNER_BR   = 2;
  localparam int CORNER_BL   = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 4'd0,
    REG_FRAME_HEIGHT = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
  } in_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] top_left_x;
    logic [OUT_W-1:0] top_left_y;
    logic [OUT_W-1:0] top_right_x;
    logic [OUT_W-1:0] top_right_y;
    logic [OUT_W-1:0] bottom_right_x;
    logic [OUT_W-1:0] bottom_right_y;
    logic [OUT_W-1:0] bottom_left_x;
    logic [OUT_W-1:0] bottom_left_y;
    logic             not_found;
  } out_item_t;

endpackage

@@ hdl/mqcf_stream_if.sv @@
// Valid/ready channel carrying one payload item per handshake.
interface mqcf_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/mqcf_cfg_regs.sv @@
// Frame size registers with range clamping.
module mqcf_cfg_regs #(
  parameter int MAX_DIM = 4096,
  localparam int DW = $clog2(MAX_DIM + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  mqcf_stream_if.sink   cfg_ch,
  output logic [DW-1:0] width,
  output logic [DW-1:0] height
);

  logic [mqcf_pkg::CFG_W-1:0] frame_width_r;
  logic [mqcf_pkg::CFG_W-1:0] frame_height_r;

  // Writes are always taken; an unknown index is dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= mqcf_pkg::FRAME_WIDTH_RST;
      frame_height_r <= mqcf_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.payload.index)
        mqcf_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_ch.payload.data;
        mqcf_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_ch.payload.data;
        default: ;
      endcase
    end
  end

  // A size of zero acts as one, a size above the maximum acts as the maximum.
  always_comb begin
    if (frame_width_r == '0) begin
      width = DW'(1);
    end else if (32'(frame_width_r) > 32'(MAX_DIM)) begin
      width = DW'(MAX_DIM);
    end else begin
      width = DW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      height = DW'(1);
    end else if (32'(frame_height_r) > 32'(MAX_DIM)) begin
      height = DW'(MAX_DIM);
    end else begin
      height = DW'(frame_height_r);
    end
  end

endmodule

@@ hdl/mqcf_scan_front.sv @@
// Raster position counters and the input register stage.
module mqcf_scan_front #(
  parameter int MAX_DIM = 4096,
  localparam int DW = $clog2(MAX_DIM + 1),
  localparam int CW = $clog2(MAX_DIM)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [DW-1:0] width,
  input  logic [DW-1:0] height,
  mqcf_stream_if.sink   in_ch,
  output logic          s1_valid,
  input  logic          s1_ready,
  output logic          s1_zero,
  output logic          s1_last,
  output logic [CW-1:0] s1_x,
  output logic [CW-1:0] s1_y,
  output logic [DW-1:0] s1_xf,
  output logic [DW-1:0] s1_yf
);

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic          s1_valid_r;
  logic          s1_zero_r, s1_last_r;
  logic [CW-1:0] s1_x_r, s1_y_r;
  logic [DW-1:0] s1_xf_r, s1_yf_r;

  logic          accept;
  logic [DW-1:0] xe, ye, xf, yf;
  logic          row_end, frame_done;

  assign in_ch.ready = !s1_valid_r || s1_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Position of the current item and its distance to the far edges.
  always_comb begin
    xe         = DW'(col_r);
    ye         = DW'(row_r);
    row_end    = (xe >= width - DW'(1));
    frame_done = row_end && (ye >= height - DW'(1));
    xf         = (xe <= width)  ? width - xe  : '0;
    yf         = (ye <= height) ? height - ye : '0;
  end

  // Counter advance: wrap the column at row end, both at frame end.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (frame_done) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (row_end) begin
      col_nxt = '0;
      row_nxt = row_r + CW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_zero_r <= (in_ch.payload.alpha == '0);
      s1_last_r <= frame_done;
      s1_x_r    <= col_r;
      s1_y_r    <= row_r;
      s1_xf_r   <= xf;
      s1_yf_r   <= yf;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_zero  = s1_zero_r;
  assign s1_last  = s1_last_r;
  assign s1_x     = s1_x_r;
  assign s1_y     = s1_y_r;
  assign s1_xf    = s1_xf_r;
  assign s1_yf    = s1_yf_r;

endmodule

@@ hdl/mqcf_square_stage.sv @@
// Squares of the near and far coordinates, registered.
module mqcf_square_stage #(
  parameter int MAX_DIM = 4096,
  localparam int DW  = $clog2(MAX_DIM + 1),
  localparam int CW  = $clog2(MAX_DIM),
  localparam int SQW = 2 * DW
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s1_valid,
  output logic           s1_ready,
  input  logic           s1_zero,
  input  logic           s1_last,
  input  logic [CW-1:0]  s1_x,
  input  logic [CW-1:0]  s1_y,
  input  logic [DW-1:0]  s1_xf,
  input  logic [DW-1:0]  s1_yf,
  output logic           s2_valid,
  input  logic           s2_ready,
  output logic           s2_zero,
  output logic           s2_last,
  output logic [CW-1:0]  s2_x,
  output logic [CW-1:0]  s2_y,
  output logic [SQW-1:0] s2_xx,
  output logic [SQW-1:0] s2_yy,
  output logic [SQW-1:0] s2_xxf,
  output logic [SQW-1:0] s2_yyf
);

  logic           s2_valid_r;
  logic           s2_zero_r, s2_last_r;
  logic [CW-1:0]  s2_x_r, s2_y_r;
  logic [SQW-1:0] s2_xx_r, s2_yy_r, s2_xxf_r, s2_yyf_r;
  logic           load;

  assign s1_ready = !s2_valid_r || s2_ready;
  assign load     = s1_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (load) begin
      s2_valid_r <= 1'b1;
    end else if (s2_ready) begin
      s2_valid_r <= 1'b0;
    end
  end

  // Four independent multipliers, one per squared term.
  always_ff @(posedge clk) begin
    if (load) begin
      s2_zero_r <= s1_zero;
      s2_last_r <= s1_last;
      s2_x_r    <= s1_x;
      s2_y_r    <= s1_y;
      s2_xx_r   <= SQW'(s1_x) * SQW'(s1_x);
      s2_yy_r   <= SQW'(s1_y) * SQW'(s1_y);
      s2_xxf_r  <= SQW'(s1_xf) * SQW'(s1_xf);
      s2_yyf_r  <= SQW'(s1_yf) * SQW'(s1_yf);
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_zero  = s2_zero_r;
  assign s2_last  = s2_last_r;
  assign s2_x     = s2_x_r;
  assign s2_y     = s2_y_r;
  assign s2_xx    = s2_xx_r;
  assign s2_yy    = s2_yy_r;
  assign s2_xxf   = s2_xxf_r;
  assign s2_yyf   = s2_yyf_r;

endmodule

@@ hdl/mqcf_corner_track.sv @@
// Per-corner best candidate registers and the result register.
module mqcf_corner_track #(
  parameter int MAX_DIM = 4096,
  localparam int DW  = $clog2(MAX_DIM + 1),
  localparam int CW  = $clog2(MAX_DIM),
  localparam int SQW = 2 * DW,
  localparam int DSW = SQW + 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s2_valid,
  output logic           s2_ready,
  input  logic           s2_zero,
  input  logic           s2_last,
  input  logic [CW-1:0]  s2_x,
  input  logic [CW-1:0]  s2_y,
  input  logic [SQW-1:0] s2_xx,
  input  logic [SQW-1:0] s2_yy,
  input  logic [SQW-1:0] s2_xxf,
  input  logic [SQW-1:0] s2_yyf,
  mqcf_stream_if.source  out_ch
);

  localparam int NC = mqcf_pkg::NUM_CORNERS;

  logic [DSW-1:0] best_d_r    [NC];
  logic [CW-1:0]  best_x_r    [NC];
  logic [CW-1:0]  best_y_r    [NC];
  logic [DSW-1:0] best_d_nxt  [NC];
  logic [CW-1:0]  best_x_nxt  [NC];
  logic [CW-1:0]  best_y_nxt  [NC];
  logic [DSW-1:0] corner_dist [NC];
  logic           any_found_r;
  logic           found_nxt;
  logic           out_valid_r;
  mqcf_pkg::out_item_t out_data_r, out_nxt;
  logic           go;

  // A frame's last item needs a free result register to move on.
  assign s2_ready = !s2_last || !out_valid_r || out_ch.ready;
  assign go       = s2_valid && s2_ready;

  // Squared distance to each corner.
  always_comb begin
    corner_dist[mqcf_pkg::CORNER_TL] = DSW'(s2_xx)  + DSW'(s2_yy);
    corner_dist[mqcf_pkg::CORNER_TR] = DSW'(s2_xxf) + DSW'(s2_yy);
    corner_dist[mqcf_pkg::CORNER_BR] = DSW'(s2_xxf) + DSW'(s2_yyf);
    corner_dist[mqcf_pkg::CORNER_BL] = DSW'(s2_xx)  + DSW'(s2_yyf);
  end

  // Replace a candidate only on a strictly smaller distance, so ties keep the earliest.
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      if (s2_zero && (!any_found_r || corner_dist[c] < best_d_r[c])) begin
        best_d_nxt[c] = corner_dist[c];
        best_x_nxt[c] = s2_x;
        best_y_nxt[c] = s2_y;
      end else begin
        best_d_nxt[c] = best_d_r[c];
        best_x_nxt[c] = best_x_r[c];
        best_y_nxt[c] = best_y_r[c];
      end
    end
    found_nxt = any_found_r || s2_zero;
  end

  // Result built from the candidates including the frame's last item.
  always_comb begin
    out_nxt = '0;
    if (found_nxt) begin
      out_nxt.top_left_x     = mqcf_pkg::OUT_W'(best_x_nxt[mqcf_pkg::CORNER_TL]);
      out_nxt.top_left_y     = mqcf_pkg::OUT_W'(best_y_nxt[mqcf_pkg::CORNER_TL]);
      out_nxt.top_right_x    = mqcf_pkg::OUT_W'(best_x_nxt[mqcf_pkg::CORNER_TR]);
      out_nxt.top_right_y    = mqcf_pkg::OUT_W'(best_y_nxt[mqcf_pkg::CORNER_TR]);
      out_nxt.bottom_right_x = mqcf_pkg::OUT_W'(best_x_nxt[mqcf_pkg::CORNER_BR]);
      out_nxt.bottom_right_y = mqcf_pkg::OUT_W'(best_y_nxt[mqcf_pkg::CORNER_BR]);
      out_nxt.bottom_left_x  = mqcf_pkg::OUT_W'(best_x_nxt[mqcf_pkg::CORNER_BL]);
      out_nxt.bottom_left_y  = mqcf_pkg::OUT_W'(best_y_nxt[mqcf_pkg::CORNER_BL]);
    end else begin
      out_nxt.not_found = 1'b1;
    end
  end

  // Control: the found flag drops at frame end, the result register handshakes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        any_found_r <= s2_last ? 1'b0 : found_nxt;
      end
      if (go && s2_last) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Candidate and result payload.
  always_ff @(posedge clk) begin
    if (go) begin
      for (int c = 0; c < NC; c++) begin
        best_d_r[c] <= best_d_nxt[c];
        best_x_r[c] <= best_x_nxt[c];
        best_y_r[c] <= best_y_nxt[c];
      end
    end
    if (go && s2_last) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_data_r;

endmodule

@@ hdl/mask_quad_corner_finder_unit.sv @@
// Top level of the mask quad corner finder.
// Throughput: one pixel item per cycle while no waiting result stalls the pipe, with no gaps between frames.
// A frame's last pixel passes the input register, the registered squaring stage, then
// sum/compare into the result register before its result is valid.
// A waiting result stalls the pipe only when the next frame's last pixel reaches it.
// Reset clears the position counters and the found flag and sets the size to 640 by 480.
module mask_quad_corner_finder_unit #(
  parameter int MAX_DIM = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  mqcf_stream_if.sink   cfg_ch,
  mqcf_stream_if.sink   in_ch,
  mqcf_stream_if.source out_ch
);

  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int CW  = $clog2(MAX_DIM);
  localparam int SQW = 2 * DW;

  logic [DW-1:0]  width, height;
  logic           s1_valid, s1_ready, s1_zero, s1_last;
  logic [CW-1:0]  s1_x, s1_y;
  logic [DW-1:0]  s1_xf, s1_yf;
  logic           s2_valid, s2_ready, s2_zero, s2_last;
  logic [CW-1:0]  s2_x, s2_y;
  logic [SQW-1:0] s2_xx, s2_yy, s2_xxf, s2_yyf;

  mqcf_cfg_regs #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .width  (width),
    .height (height)
  );

  mqcf_scan_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .width    (width),
    .height   (height),
    .in_ch    (in_ch),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_zero  (s1_zero),
    .s1_last  (s1_last),
    .s1_x     (s1_x),
    .s1_y     (s1_y),
    .s1_xf    (s1_xf),
    .s1_yf    (s1_yf)
  );

  mqcf_square_stage #(.MAX_DIM(MAX_DIM)) u_square (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_zero  (s1_zero),
    .s1_last  (s1_last),
    .s1_x     (s1_x),
    .s1_y     (s1_y),
    .s1_xf    (s1_xf),
    .s1_yf    (s1_yf),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_zero  (s2_zero),
    .s2_last  (s2_last),
    .s2_x     (s2_x),
    .s2_y     (s2_y),
    .s2_xx    (s2_xx),
    .s2_yy    (s2_yy),
    .s2_xxf   (s2_xxf),
    .s2_yyf   (s2_yyf)
  );

  mqcf_corner_track #(.MAX_DIM(MAX_DIM)) u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_zero  (s2_zero),
    .s2_last  (s2_last),
    .s2_x     (s2_x),
    .s2_y     (s2_y),
    .s2_xx    (s2_xx),
    .s2_yy    (s2_yy),
    .s2_xxf   (s2_xxf),
    .s2_yyf   (s2_yyf),
    .out_ch   (out_ch)
  );

endmodule

@@ hdl/mqcf_checker.sv @@
// Port-level checks on the result channel, bound to the top level.
module mqcf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input mqcf_pkg::out_item_t out_data
);

  // A result waiting for the sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item withdrawn while stalled");

  // A stalled result does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result item changed while stalled");

  // Reset leaves no result on offer.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item offered after reset");

  // An empty frame reports all coordinates as zero.
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.not_found |->
      out_data.top_left_x == '0 && out_data.top_left_y == '0 &&
      out_data.top_right_x == '0 && out_data.top_right_y == '0 &&
      out_data.bottom_right_x == '0 && out_data.bottom_right_y == '0 &&
      out_data.bottom_left_x == '0 && out_data.bottom_left_y == '0)
    else $error("empty frame result carries coordinates");

endmodule

bind mask_quad_corner_finder_unit mqcf_checker u_mqcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.payload)
);
